// ===== design/plf_pkg.sv =====
package plf_pkg;

    // Field and register widths.
    localparam int DEPTH_WIDTH = 20;
    localparam int COUNT_WIDTH = 16;
    localparam int CFG_DATA_WIDTH = (DEPTH_WIDTH > COUNT_WIDTH) ? DEPTH_WIDTH : COUNT_WIDTH;
    localparam int CFG_INDEX_WIDTH = 1;

    // Configuration register indexes and reset values.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_DEPTH = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_ALT_DEPTH = CFG_INDEX_WIDTH'(1);
    localparam logic [DEPTH_WIDTH-1:0] MIN_DEPTH_RESET = DEPTH_WIDTH'(10);
    localparam logic [COUNT_WIDTH-1:0] MIN_ALT_DEPTH_RESET = COUNT_WIDTH'(2);

    // Column phase codes: three leading columns, then depth, reads, ignored.
    localparam logic [2:0] PHASE_FIRST = 3'd0;
    localparam logic [2:0] PHASE_DEPTH = 3'd3;
    localparam logic [2:0] PHASE_READS = 3'd4;
    localparam logic [2:0] PHASE_OTHER = 3'd5;

    // Number decode stages.
    localparam logic [1:0] NUM_BEFORE = 2'd0;
    localparam logic [1:0] NUM_DIGITS = 2'd1;
    localparam logic [1:0] NUM_DONE = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_VT = 8'd11;
    localparam logic [7:0] CH_FF = 8'd12;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UC = 8'h43;
    localparam logic [7:0] CH_UG = 8'h47;
    localparam logic [7:0] CH_UN = 8'h4E;
    localparam logic [7:0] CH_UT = 8'h54;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LC = 8'h63;
    localparam logic [7:0] CH_LG = 8'h67;
    localparam logic [7:0] CH_LN = 8'h6E;
    localparam logic [7:0] CH_LT = 8'h74;

    // True for a base letter in either case.
    function automatic logic is_base(input logic [7:0] c);
        return c inside {CH_UA, CH_UC, CH_UG, CH_UN, CH_UT,
                         CH_LA, CH_LC, CH_LG, CH_LN, CH_LT};
    endfunction

    // True for white space skipped ahead of a number.
    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, CH_VT, CH_FF, CH_CR};
    endfunction

endpackage

// ===== design/plf_if.sv =====
interface plf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

interface plf_out_if;
    logic valid;
    logic ready;
    logic keep;
    logic depth_ok;
    logic alt_ok;

    modport source (output valid, output keep, output depth_ok, output alt_ok, input ready);
    modport sink (input valid, input keep, input depth_ok, input alt_ok, output ready);
endinterface

interface plf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [plf_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [plf_pkg::CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/pileup_line_depth_filter_top.sv =====
// Pileup line depth filter.
//
// The din channel carries one byte of pileup text per item (ch), with last
// marking the final byte of the stream. The dout channel carries one item per
// finished line: depth_ok says some depth column reached min_depth, alt_ok
// says some read column held at least min_alt_depth base letters, and keep is
// both together. A line finishes at a newline byte or at a byte with last set.
// The cfg channel writes min_depth (index 0) and min_alt_depth (index 1); it
// is always ready and should only be used while no line is in flight.
//
// Throughput is one byte per cycle. A byte is taken into an input register,
// then all parsing for it is done in narrow combinational logic (a shift-add
// times ten on the depth value and two threshold compares). The result of the
// closing byte is then registered in the output register, where it waits until the
// receiver accepts it. If the receiver stalls, the pending result is held;
// bytes that do not end a line keep flowing, and the byte that would end the
// next line waits in the input register until the output register frees up.
// Reset clears all parse state, empties both registers and loads the default
// thresholds of 10 and 2.
module pileup_line_depth_filter_top
(
    input logic        clk,
    input logic        rst_n,
    plf_in_if.sink     din,
    plf_out_if.source  dout,
    plf_cfg_if.sink    cfg
);

    localparam int DW = plf_pkg::DEPTH_WIDTH;
    localparam int CW = plf_pkg::COUNT_WIDTH;

    // Threshold registers.
    logic [DW-1:0] min_depth_reg;
    logic [CW-1:0] min_alt_depth_reg;

    // Input register.
    logic          s1_valid_reg, s1_valid_next;
    logic [7:0]    s1_ch_reg;
    logic          s1_last_reg;

    // Parse state.
    logic [2:0]    phase_reg, phase_next;
    logic [DW-1:0] depth_value_reg, depth_value_next;
    logic [1:0]    num_stage_reg, num_stage_next;
    logic          neg_reg, neg_next;
    logic          skip_reg, skip_next;
    logic [CW-1:0] count_reg, count_next;
    logic          nonempty_reg, nonempty_next;
    logic          depth_seen_reg, depth_seen_next;
    logic          alt_seen_reg, alt_seen_next;

    // Result register.
    logic          out_valid_reg, out_valid_next;
    logic          keep_reg, depth_ok_reg, alt_ok_reg;

    // Per-byte decode.
    logic          is_tab, is_lf, is_data, emit, advance, close_en;
    logic          is_digit;
    logic [DW+3:0] depth_wide;
    logic [DW-1:0] depth_upd;
    logic [1:0]    stage_upd;
    logic          neg_upd, skip_upd;
    logic [CW-1:0] count_upd;
    logic [DW-1:0] eval_depth;
    logic          eval_neg;
    logic [CW-1:0] eval_count;
    logic          depth_pass, alt_pass;
    logic          depth_seen_upd, alt_seen_upd;

    assign is_tab  = (s1_ch_reg == plf_pkg::CH_TAB);
    assign is_lf   = (s1_ch_reg == plf_pkg::CH_LF);
    assign is_data = !is_tab && !is_lf;
    assign emit    = is_lf || s1_last_reg;

    // A byte that ends a line needs the output register; other bytes never wait.
    assign advance   = s1_valid_reg && (!emit || !out_valid_reg || dout.ready);
    assign din.ready = !s1_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign is_digit = (s1_ch_reg >= plf_pkg::CH_0) && (s1_ch_reg <= plf_pkg::CH_9);

    // depth * 10 + digit, saturated to the field width.
    assign depth_wide = ({4'b0, depth_value_reg} << 3) + ({4'b0, depth_value_reg} << 1)
                      + (DW+4)'(s1_ch_reg[3:0]);

    // Field state after taking the current byte as data.
    always_comb
    begin
        depth_upd = depth_value_reg;
        stage_upd = num_stage_reg;
        neg_upd   = neg_reg;
        skip_upd  = skip_reg;
        count_upd = count_reg;
        if (phase_reg == plf_pkg::PHASE_DEPTH)
        begin
            if (num_stage_reg == plf_pkg::NUM_BEFORE && plf_pkg::is_space(s1_ch_reg))
            begin
                stage_upd = plf_pkg::NUM_BEFORE;
            end
            else if (num_stage_reg == plf_pkg::NUM_BEFORE &&
                     (s1_ch_reg == plf_pkg::CH_PLUS || s1_ch_reg == plf_pkg::CH_MINUS))
            begin
                neg_upd   = (s1_ch_reg == plf_pkg::CH_MINUS);
                stage_upd = plf_pkg::NUM_DIGITS;
            end
            else if (num_stage_reg != plf_pkg::NUM_DONE)
            begin
                if (is_digit)
                begin
                    stage_upd = plf_pkg::NUM_DIGITS;
                    depth_upd = (|depth_wide[DW+3:DW]) ? {DW{1'b1}} : depth_wide[DW-1:0];
                end
                else
                begin
                    stage_upd = plf_pkg::NUM_DONE;
                end
            end
        end
        else if (phase_reg == plf_pkg::PHASE_READS)
        begin
            if (skip_reg)
            begin
                skip_upd = 1'b0;
            end
            else if (s1_ch_reg == plf_pkg::CH_CARET)
            begin
                skip_upd = 1'b1;
            end
            else if (plf_pkg::is_base(s1_ch_reg) && !(&count_reg))
            begin
                count_upd = count_reg + CW'(1);
            end
        end
    end

    // Field evaluation: a tab, or a newline ending a nonempty field, closes it as
    // it stands; a final data byte closes it after that byte is taken in.
    assign eval_depth = is_data ? depth_upd : depth_value_reg;
    assign eval_neg   = is_data ? neg_upd : neg_reg;
    assign eval_count = is_data ? count_upd : count_reg;
    assign close_en   = is_tab || (is_lf && nonempty_reg) || (is_data && s1_last_reg);

    assign depth_pass = (phase_reg == plf_pkg::PHASE_DEPTH) &&
                        !(eval_neg && (eval_depth != '0)) && (eval_depth >= min_depth_reg);
    assign alt_pass   = (phase_reg == plf_pkg::PHASE_READS) && (eval_count >= min_alt_depth_reg);

    assign depth_seen_upd = depth_seen_reg || (close_en && depth_pass);
    assign alt_seen_upd   = alt_seen_reg || (close_en && alt_pass);

    always_comb
    begin
        s1_valid_next    = s1_valid_reg;
        phase_next       = phase_reg;
        depth_value_next = depth_value_reg;
        num_stage_next   = num_stage_reg;
        neg_next         = neg_reg;
        skip_next        = skip_reg;
        count_next       = count_reg;
        nonempty_next    = nonempty_reg;
        depth_seen_next  = depth_seen_reg;
        alt_seen_next    = alt_seen_reg;
        out_valid_next   = out_valid_reg;

        if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (din.valid && din.ready)
        begin
            s1_valid_next = 1'b1;
        end

        if (out_valid_reg && dout.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (advance)
        begin
            if (emit)
            begin
                out_valid_next   = 1'b1;
                phase_next       = plf_pkg::PHASE_FIRST;
                depth_seen_next  = 1'b0;
                alt_seen_next    = 1'b0;
                depth_value_next = '0;
                num_stage_next   = plf_pkg::NUM_BEFORE;
                neg_next         = 1'b0;
                skip_next        = 1'b0;
                count_next       = '0;
                nonempty_next    = 1'b0;
            end
            else if (is_tab)
            begin
                depth_seen_next  = depth_seen_upd;
                alt_seen_next    = alt_seen_upd;
                phase_next       = (phase_reg == plf_pkg::PHASE_OTHER) ?
                                   plf_pkg::PHASE_DEPTH : phase_reg + 3'd1;
                depth_value_next = '0;
                num_stage_next   = plf_pkg::NUM_BEFORE;
                neg_next         = 1'b0;
                skip_next        = 1'b0;
                count_next       = '0;
                nonempty_next    = 1'b0;
            end
            else
            begin
                depth_value_next = depth_upd;
                num_stage_next   = stage_upd;
                neg_next         = neg_upd;
                skip_next        = skip_upd;
                count_next       = count_upd;
                nonempty_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_depth_reg     <= plf_pkg::MIN_DEPTH_RESET;
            min_alt_depth_reg <= plf_pkg::MIN_ALT_DEPTH_RESET;
            s1_valid_reg      <= 1'b0;
            phase_reg         <= plf_pkg::PHASE_FIRST;
            depth_value_reg   <= '0;
            num_stage_reg     <= plf_pkg::NUM_BEFORE;
            neg_reg           <= 1'b0;
            skip_reg          <= 1'b0;
            count_reg         <= '0;
            nonempty_reg      <= 1'b0;
            depth_seen_reg    <= 1'b0;
            alt_seen_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    plf_pkg::REG_MIN_DEPTH:     min_depth_reg <= cfg.data[DW-1:0];
                    plf_pkg::REG_MIN_ALT_DEPTH: min_alt_depth_reg <= cfg.data[CW-1:0];
                    default:                    min_depth_reg <= min_depth_reg;
                endcase
            end
            s1_valid_reg    <= s1_valid_next;
            phase_reg       <= phase_next;
            depth_value_reg <= depth_value_next;
            num_stage_reg   <= num_stage_next;
            neg_reg         <= neg_next;
            skip_reg        <= skip_next;
            count_reg       <= count_next;
            nonempty_reg    <= nonempty_next;
            depth_seen_reg  <= depth_seen_next;
            alt_seen_reg    <= alt_seen_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
        begin
            s1_ch_reg   <= din.ch;
            s1_last_reg <= din.last;
        end
        if (advance && emit)
        begin
            keep_reg     <= depth_seen_upd && alt_seen_upd;
            depth_ok_reg <= depth_seen_upd;
            alt_ok_reg   <= alt_seen_upd;
        end
    end

    assign dout.valid    = out_valid_reg;
    assign dout.keep     = keep_reg;
    assign dout.depth_ok = depth_ok_reg;
    assign dout.alt_ok   = alt_ok_reg;

    // A result only appears with both flags agreeing with keep.
    assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> (dout.keep == (dout.depth_ok && dout.alt_ok)))
        else $error("keep disagrees with depth_ok and alt_ok");

    // The column phase never passes the ignored column.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= plf_pkg::PHASE_OTHER)
        else $error("column phase out of range");

    // Ending a line leaves the line state cleared and a result pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> (out_valid_reg && phase_reg == plf_pkg::PHASE_FIRST &&
                               !depth_seen_reg && !alt_seen_reg && !nonempty_reg))
        else $error("line state not cleared after a result");

    // A byte held in the input register stays put until it is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_ch_reg) &&
                                        $stable(s1_last_reg)))
        else $error("input register changed while stalled");

    // A stalled result is never overwritten by a new line end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !dout.ready) |-> !(advance && emit))
        else $error("pending result overwritten");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

// The testbench feeds pileup text into the filter one byte per item and checks
// one verdict item per finished line. A model of the line parser, kept inside
// this module, follows every accepted byte and queues the verdict that the
// block should give. The monitor compares each verdict from the block with the
// oldest queued one.
module testbench;
    import plf_pkg::*;

    localparam int CLK_PERIOD = 4;
    localparam int CYCLE_LIMIT = 1_000_000;
    // Verdicts leave the block through its input and result registers; this
    // margin lets anything still in flight surface.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BYTES = 550;
    localparam int RANDOM_LINES = 15;
    localparam int LINES_PER_PHASE = 3;
    localparam logic [DEPTH_WIDTH-1:0] DEPTH_TOP = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;
    localparam longint unsigned DEPTH_CAP = (64'd1 << DEPTH_WIDTH) - 64'd1;

    localparam logic [7:0] BASES [10] = '{CH_UA, CH_UC, CH_UG, CH_UN, CH_UT,
                                          CH_LA, CH_LC, CH_LG, CH_LN, CH_LT};
    localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_VT, CH_FF, CH_CR};

    typedef struct packed {
        logic keep;
        logic depth_ok;
        logic alt_ok;
    } line_verdict_t;

    typedef struct packed {
        logic [7:0]    ch;
        logic          last;
        logic          typed;
        line_verdict_t verdict;
    } text_row_t;

    // The opening rows cover the empty line, the two extreme byte values in a
    // leading column, a line that just meets the reset thresholds, a negative
    // depth with a skipped base after a caret that ends on a final byte, and a
    // bare newline that also carries the final-byte flag. Each verdict here
    // can be read straight off the text.
    localparam text_row_t OPENING_ROWS [23] = '{
        '{CH_LF,       1'b0, 1'b1, 3'b000},
        '{8'hFF,       1'b0, 1'b0, 3'b000},
        '{8'h00,       1'b0, 1'b0, 3'b000},
        '{CH_TAB,      1'b0, 1'b0, 3'b000},
        '{CH_TAB,      1'b0, 1'b0, 3'b000},
        '{CH_TAB,      1'b0, 1'b0, 3'b000},
        '{CH_SPACE,    1'b0, 1'b0, 3'b000},
        '{CH_0 + 8'd1, 1'b0, 1'b0, 3'b000},
        '{CH_0,        1'b0, 1'b0, 3'b000},
        '{CH_TAB,      1'b0, 1'b0, 3'b000},
        '{CH_UA,       1'b0, 1'b0, 3'b000},
        '{CH_LA,       1'b0, 1'b0, 3'b000},
        '{CH_LF,       1'b0, 1'b1, 3'b111},
        '{CH_TAB,      1'b0, 1'b0, 3'b000},
        '{CH_TAB,      1'b0, 1'b0, 3'b000},
        '{CH_TAB,      1'b0, 1'b0, 3'b000},
        '{CH_MINUS,    1'b0, 1'b0, 3'b000},
        '{CH_0 + 8'd5, 1'b0, 1'b0, 3'b000},
        '{CH_TAB,      1'b0, 1'b0, 3'b000},
        '{CH_CARET,    1'b0, 1'b0, 3'b000},
        '{CH_UA,       1'b0, 1'b0, 3'b000},
        '{CH_UN,       1'b1, 1'b1, 3'b000},
        '{CH_LF,       1'b1, 1'b1, 3'b000}
    };

    logic clk = 1'b0;
    logic rst_n;

    plf_in_if  byte_bus ();
    plf_out_if line_bus ();
    plf_cfg_if cfg_bus ();

    pileup_line_depth_filter_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (byte_bus),
        .dout  (line_bus),
        .cfg   (cfg_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Thresholds as the block should hold them.
    logic [DEPTH_WIDTH-1:0] thr_depth = MIN_DEPTH_RESET;
    logic [COUNT_WIDTH-1:0] thr_alt = MIN_ALT_DEPTH_RESET;

    // Parser state of the line model.
    logic [2:0]             col_phase = PHASE_FIRST;
    logic [DEPTH_WIDTH-1:0] depth_acc = '0;
    logic [1:0]             num_stage = NUM_BEFORE;
    logic                   depth_neg = 1'b0;
    logic                   skip_after_caret = 1'b0;
    logic [COUNT_WIDTH-1:0] base_count = '0;
    logic                   column_used = 1'b0;
    logic                   depth_hit = 1'b0;
    logic                   alt_hit = 1'b0;

    line_verdict_t verdict_q [$];
    int unsigned   mismatches = 0;
    int unsigned   cycles = 0;
    int unsigned   random_bytes = 0;
    int unsigned   random_lines = 0;
    // While calm is set, the sender never idles before a byte and the receiver never stalls.
    bit            calm = 1'b0;

    function automatic void clear_column();
        depth_acc = '0;
        num_stage = NUM_BEFORE;
        depth_neg = 1'b0;
        skip_after_caret = 1'b0;
        base_count = '0;
        column_used = 1'b0;
    endfunction

    // A depth column passes on its saturated magnitude unless it carries a
    // minus sign and a nonzero value; a read column passes on its base count.
    function automatic void close_column();
        if (col_phase == PHASE_DEPTH) begin
            if (!(depth_neg && depth_acc != '0) && depth_acc >= thr_depth)
                depth_hit = 1'b1;
        end
        else if (col_phase == PHASE_READS) begin
            if (base_count >= thr_alt)
                alt_hit = 1'b1;
        end
    endfunction

    function automatic void take_column_byte(input logic [7:0] c);
        longint unsigned wide;
        if (c == CH_TAB) begin
            close_column();
            col_phase = (col_phase >= PHASE_OTHER) ? PHASE_DEPTH : col_phase + 3'd1;
            clear_column();
        end
        else begin
            column_used = 1'b1;
            if (col_phase == PHASE_DEPTH) begin
                if (num_stage == NUM_BEFORE && (c == CH_PLUS || c == CH_MINUS)) begin
                    depth_neg = (c == CH_MINUS);
                    num_stage = NUM_DIGITS;
                end
                else if (num_stage == NUM_DIGITS ||
                         (num_stage == NUM_BEFORE && !(c inside {BLANKS}))) begin
                    num_stage = NUM_DIGITS;
                    if (c >= CH_0 && c <= CH_9) begin
                        wide = 64'(depth_acc) * 64'd10 + 64'(c - CH_0);
                        depth_acc = (wide > DEPTH_CAP) ? DEPTH_TOP : DEPTH_WIDTH'(wide);
                    end
                    else begin
                        num_stage = NUM_DONE;
                    end
                end
            end
            else if (col_phase == PHASE_READS) begin
                if (skip_after_caret)
                    skip_after_caret = 1'b0;
                else if (c == CH_CARET)
                    skip_after_caret = 1'b1;
                else if (c inside {BASES} && base_count != COUNT_TOP)
                    base_count = base_count + COUNT_WIDTH'(1);
            end
        end
    endfunction

    // A trailing column that is still empty when the line ends is not judged.
    function automatic void finish_line(output line_verdict_t v);
        if (column_used)
            close_column();
        v.keep = depth_hit && alt_hit;
        v.depth_ok = depth_hit;
        v.alt_ok = alt_hit;
        clear_column();
        col_phase = PHASE_FIRST;
        depth_hit = 1'b0;
        alt_hit = 1'b0;
    endfunction

    // Advances the line model by one byte; returns 1 when a line closes.
    function automatic bit predict_line_end(input logic [7:0] c, input logic fin,
                                            output line_verdict_t v);
        v = '0;
        if (c == CH_LF) begin
            finish_line(v);
            return 1'b1;
        end
        take_column_byte(c);
        if (fin) begin
            finish_line(v);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offers one byte item, idling first at random unless calm is set, and
    // queues the verdict it closes once the block takes it. Valid is left high
    // after the handshake so that the next item can follow without a gap.
    task automatic send_byte(input logic [7:0] c, input logic fin, input logic typed,
                             input line_verdict_t typed_verdict);
        line_verdict_t v;
        if (!calm && $urandom_range(0, 99) < 25) begin
            byte_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        byte_bus.valid <= 1'b1;
        byte_bus.ch <= c;
        byte_bus.last <= fin;
        do @(posedge clk); while (!byte_bus.ready);
        if (predict_line_end(c, fin, v))
            verdict_q.insert(verdict_q.size(), typed ? typed_verdict : v);
    endtask

    // Builds one line of random content and sends it. Most lines are well
    // formed with random columns; some are pure noise, some are cut short and
    // some end on a tab so that the last column stays empty.
    task automatic send_line();
        logic [7:0] text [$];
        int         samples;
        int         k;
        int         sel;
        int         pick;
        int         cut;
        bit         close_on_last;
        bit         no_digits;
        longint unsigned v;
        string      digits;
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(0, 30))
                text.insert(text.size(),
                            ($urandom_range(0, 7) == 0) ? CH_TAB : 8'($urandom_range(0, 255)));
        end
        else begin
            repeat (3) begin
                repeat ($urandom_range(0, 3)) text.insert(text.size(), 8'($urandom_range(33, 126)));
                text.insert(text.size(), CH_TAB);
            end
            samples = $urandom_range(1, 4);
            for (k = 0; k < samples; k++) begin
                // Depth column: blanks, an optional sign, digits and maybe junk.
                if ($urandom_range(0, 19) != 0) begin
                    repeat ($urandom_range(0, 2))
                        text.insert(text.size(), BLANKS[$urandom_range(0, 3)]);
                    sel = $urandom_range(0, 9);
                    if (sel == 0)
                        text.insert(text.size(), CH_PLUS);
                    else if (sel == 1)
                        text.insert(text.size(), CH_MINUS);
                    pick = $urandom_range(0, 9);
                    no_digits = (pick == 9);
                    if (sel == 1 && pick < 3)
                        v = 0;
                    else if (pick < 5)
                        v = $urandom_range(0, thr_depth + 3);
                    else if (pick < 7)
                        v = $urandom_range(0, 30);
                    else
                        v = {$urandom, $urandom};
                    if (!no_digits) begin
                        digits = $sformatf("%0d", v);
                        foreach (digits[j]) text.insert(text.size(), digits[j]);
                    end
                    if ($urandom_range(0, 4) == 0)
                        text.insert(text.size(), ($urandom_range(0, 3) == 0) ? 8'h00 :
                                                 8'($urandom_range(33, 126)));
                end
                text.insert(text.size(), CH_TAB);
                // Read column: mostly bases, some carets and other bytes.
                repeat ($urandom_range(0, (thr_alt > 8) ? 10 : thr_alt + 3)) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 6)
                        text.insert(text.size(), BASES[$urandom_range(0, 9)]);
                    else if (sel == 6)
                        text.insert(text.size(), CH_CARET);
                    else
                        text.insert(text.size(), 8'($urandom_range(11, 255)));
                end
                if (k != samples - 1 || $urandom_range(0, 1) == 1) begin
                    text.insert(text.size(), CH_TAB);
                    repeat ($urandom_range(0, 3))
                        text.insert(text.size(), 8'($urandom_range(33, 126)));
                    if (k != samples - 1)
                        text.insert(text.size(), CH_TAB);
                end
            end
            if ($urandom_range(0, 4) == 0) begin
                cut = $urandom_range(0, text.size());
                while (text.size() > cut) void'(text.pop_back());
            end
            if ($urandom_range(0, 6) == 0)
                text.insert(text.size(), CH_TAB);
        end
        // The line closes on a newline, on a newline with the final-byte flag,
        // or on its own last byte carrying that flag.
        sel = $urandom_range(0, 9);
        close_on_last = (sel < 3 && text.size() != 0);
        foreach (text[j])
            send_byte(text[j], close_on_last && j == text.size() - 1, 1'b0, '0);
        if (!close_on_last)
            send_byte(CH_LF, sel >= 8, 1'b0, '0);
        random_bytes += text.size() + (close_on_last ? 0 : 1);
        random_lines++;
    endtask

    // Writes both thresholds while the block is idle.
    task automatic set_thresholds(input logic [DEPTH_WIDTH-1:0] d,
                                  input logic [COUNT_WIDTH-1:0] a);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= REG_MIN_DEPTH;
        cfg_bus.data <= CFG_DATA_WIDTH'(d);
        do @(posedge clk); while (!cfg_bus.ready);
        thr_depth = d;
        cfg_bus.index <= REG_MIN_ALT_DEPTH;
        cfg_bus.data <= CFG_DATA_WIDTH'(a);
        do @(posedge clk); while (!cfg_bus.ready);
        thr_alt = a;
        cfg_bus.valid <= 1'b0;
    endtask

    // Waits for every queued verdict, then lets the pipeline run dry.
    task automatic drain_verdicts();
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: stalls at random unless calm is set, and checks every verdict
    // item that the block hands over against the oldest queued one.
    always @(posedge clk) begin : verdict_check
        line_verdict_t want;
        if (rst_n && line_bus.valid && line_bus.ready) begin
            if (verdict_q.size() == 0) begin
                $error("line verdict with none expected: keep=%0b depth_ok=%0b alt_ok=%0b",
                       line_bus.keep, line_bus.depth_ok, line_bus.alt_ok);
                mismatches++;
            end
            else begin
                want = verdict_q.pop_front();
                if (line_bus.keep !== want.keep) begin
                    $error("keep: expected %0b, got %0b", want.keep, line_bus.keep);
                    mismatches++;
                end
                if (line_bus.depth_ok !== want.depth_ok) begin
                    $error("depth_ok: expected %0b, got %0b", want.depth_ok, line_bus.depth_ok);
                    mismatches++;
                end
                if (line_bus.alt_ok !== want.alt_ok) begin
                    $error("alt_ok: expected %0b, got %0b", want.alt_ok, line_bus.alt_ok);
                    mismatches++;
                end
            end
        end
        line_bus.ready <= calm || ($urandom_range(0, 99) >= 25);
    end

    // A run that hangs, for instance on a verdict that never comes, ends here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("pileup_line_depth_filter_top verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        logic [DEPTH_WIDTH-1:0] d;
        logic [COUNT_WIDTH-1:0] a;
        rst_n <= 1'b0;
        byte_bus.valid <= 1'b0;
        byte_bus.ch <= '0;
        byte_bus.last <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= REG_MIN_DEPTH;
        cfg_bus.data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening rows run on the reset thresholds.
        foreach (OPENING_ROWS[i])
            send_byte(OPENING_ROWS[i].ch, OPENING_ROWS[i].last, OPENING_ROWS[i].typed,
                      OPENING_ROWS[i].verdict);
        byte_bus.valid <= 1'b0;
        drain_verdicts();

        // Random lines in phases. The first phases pin the thresholds to their
        // extremes; later ones pick values that random depths and counts
        // straddle. Every phase ends with the sender holding off until all of
        // its verdicts are in, and one phase runs with no idling at all.
        phase = 0;
        while (random_bytes < RANDOM_BYTES || random_lines < RANDOM_LINES) begin
            case (phase)
                0: begin d = '0; a = '0; end
                1: begin d = DEPTH_TOP; a = COUNT_TOP; end
                2: begin d = DEPTH_TOP; a = '0; end
                3: begin d = '0; a = COUNT_TOP; end
                default: begin
                    d = DEPTH_WIDTH'($urandom_range(0, 40));
                    a = COUNT_WIDTH'($urandom_range(0, 6));
                end
            endcase
            set_thresholds(d, a);
            calm = (phase == 4);
            repeat (LINES_PER_PHASE) send_line();
            byte_bus.valid <= 1'b0;
            drain_verdicts();
            calm = 1'b0;
            phase++;
        end

        if (mismatches == 0)
            $display("pileup_line_depth_filter_top verification clean");
        else
            $display("pileup_line_depth_filter_top verification failed");
        $finish;
    end

endmodule
